FILE: rtl/core/pgfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgfm_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * BYTE_W;
    localparam int MODE_W    = 3;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SLASH = 8'h2F;

    // Match modes
    localparam logic [MODE_W-1:0] MODE_ROOT_EXACT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROOT_DIR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ANY_DIR    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LAST_EXACT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAST_START = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LAST_END   = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  len;
        logic [PAT_W-1:0]  pat;   // byte i at bits 8i
    } t_cfg;

    typedef struct packed {
        logic step;    // advance on one path byte
        logic clear;   // end of path: drop all path state
    } t_trk_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/path_glob_filter_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Path glob filter. Stream a path one byte per request on the slave side and
// finish it with a request that has tlast set (its data byte is ignored); that
// request yields one verdict on the master side, bit 0 of tdata, and returns
// the path state to reset. Modes: rooted exact, rooted prefix ending at '/'
// or the path end, pattern found anywhere before '/' or the end, last
// component equal to, starting with or ending with the pattern. The pattern
// (up to MAX_PATTERN bytes, stars already stripped in software) and the mode
// are written through the configuration channel, by the user only while the
// block is idle, which the block does not enforce; lengths above MAX_PATTERN
// act as MAX_PATTERN, modes 6 and 7 never match. Throughput is one request
// per clock while no end request stalls: every window compare runs in parallel
// in the single stage between the input register and the verdict register.
// Byte requests keep flowing while a verdict waits for tready; an end request
// waits in the input register, stalling the input side, until the verdict
// register is free, and its verdict is then loaded there and presented.

module path_glob_filter_match
    import pgfm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Path bytes
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [7:0]           i_s_tdata,   // [7:0] path_byte
    input  wire logic                 i_s_tlast,   // path_end
    // Verdicts
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [7:0]                o_m_tdata,   // [0] matched, [7:1] zero
    // Configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]  r_len;
    logic [CFG_W-1:0]  r_pat_lo;
    logic [CFG_W-1:0]  r_pat_hi;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Verdict register
    logic              r_out_valid;
    logic              r_matched;

    logic      consume;
    logic      out_free;
    logic      match;
    t_cfg      cfg;
    t_trk_ctrl ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_len    <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MATCH_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_PATTERN_LEN:  r_len    <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                REG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                default:          r_mode   <= r_mode;
            endcase
        end
    end

    assign cfg.mode = r_mode;
    assign cfg.len  = r_len;
    assign cfg.pat  = {r_pat_hi, r_pat_lo};

    // A byte request always advances; an end request needs a free verdict slot
    assign out_free = !r_out_valid || i_m_tready;
    assign consume  = r_in_valid && (!r_in_last || out_free);

    assign o_s_tready = !r_in_valid || consume;

    assign ctrl.step  = consume && !r_in_last;
    assign ctrl.clear = consume && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    pgfm_track #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctrl  (ctrl),
        .i_byte  (r_in_byte),
        .o_match (match)
    );

    // Hold the verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.clear) begin
            r_matched <= match;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_matched};

endmodule

`default_nettype wire

FILE: rtl/core/pgfm_track.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfm_track
    import pgfm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire t_trk_ctrl         i_ctrl,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_match
);

    localparam int PW = $clog2(MAX_PATTERN + 2);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [PW-1:0] SAT = PW'(MAX_PATTERN + 1);

    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [PW-1:0]     r_path_pos, n_path_pos;
    logic [PW-1:0]     r_comp_pos, n_comp_pos;
    logic              r_root_mis, n_root_mis;
    logic              r_root_ok,  n_root_ok;
    logic              r_comp_mis, n_comp_mis;
    logic              r_any_hit,  n_any_hit;

    logic [BYTE_W-1:0]    pat [MAX_PATTERN];
    logic [LW-1:0]        len_c;
    logic [PW-1:0]        len_p;
    logic [MAX_PATTERN:0] eq_len;
    logic                 win_eq;
    logic                 is_slash;

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pat[j] = i_cfg.pat[BYTE_W*j +: BYTE_W];
        end
    end

    assign len_c = (i_cfg.len > LEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(i_cfg.len);
    assign len_p = PW'(len_c);

    // Window tail of each possible length against the pattern head
    always_comb begin
        for (int l = 0; l <= MAX_PATTERN; l++) begin
            eq_len[l] = 1'b1;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (j < l) begin
                    eq_len[l] = eq_len[l] & (r_win[l-1-j] == pat[j]);
                end
            end
        end
    end

    assign win_eq   = eq_len[len_c];
    assign is_slash = (i_byte == SLASH);

    always_comb begin
        n_path_pos = r_path_pos;
        n_comp_pos = r_comp_pos;
        n_root_mis = r_root_mis;
        n_root_ok  = r_root_ok;
        n_comp_mis = r_comp_mis;
        n_any_hit  = r_any_hit;
        if (i_ctrl.clear) begin
            n_path_pos = '0;
            n_comp_pos = '0;
            n_root_mis = 1'b0;
            n_root_ok  = 1'b0;
            n_comp_mis = 1'b0;
            n_any_hit  = 1'b0;
        end else if (i_ctrl.step) begin
            if ((r_path_pos < len_p) && (i_byte != pat[r_path_pos[IW-1:0]])) begin
                n_root_mis = 1'b1;
            end
            if ((r_path_pos == len_p) && is_slash) begin
                n_root_ok = 1'b1;
            end
            if (is_slash && (r_path_pos >= len_p) && win_eq) begin
                n_any_hit = 1'b1;
            end
            if (is_slash) begin
                n_comp_pos = '0;
                n_comp_mis = 1'b0;
            end else begin
                if ((r_comp_pos < len_p) && (i_byte != pat[r_comp_pos[IW-1:0]])) begin
                    n_comp_mis = 1'b1;
                end
                if (r_comp_pos < SAT) begin
                    n_comp_pos = r_comp_pos + PW'(1);
                end
            end
            if (r_path_pos < SAT) begin
                n_path_pos = r_path_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_pos <= '0;
            r_comp_pos <= '0;
            r_root_mis <= 1'b0;
            r_root_ok  <= 1'b0;
            r_comp_mis <= 1'b0;
            r_any_hit  <= 1'b0;
        end else begin
            r_path_pos <= n_path_pos;
            r_comp_pos <= n_comp_pos;
            r_root_mis <= n_root_mis;
            r_root_ok  <= n_root_ok;
            r_comp_mis <= n_comp_mis;
            r_any_hit  <= n_any_hit;
        end
    end

    // Entries older than the current path are never read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_win[0] <= i_byte;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_comb begin
        case (i_cfg.mode)
            MODE_ROOT_EXACT: o_match = !r_root_mis && (r_path_pos == len_p);
            MODE_ROOT_DIR:   o_match = !r_root_mis && ((r_path_pos == len_p) || r_root_ok);
            MODE_ANY_DIR:    o_match = r_any_hit || ((r_path_pos >= len_p) && win_eq);
            MODE_LAST_EXACT: o_match = !r_comp_mis && (r_comp_pos == len_p);
            MODE_LAST_START: o_match = !r_comp_mis && (r_comp_pos >= len_p);
            MODE_LAST_END:   o_match = (r_comp_pos >= len_p) && win_eq;
            default:         o_match = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pgfm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_cfg_ready
);

    // No verdict right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("verdict valid after reset");

    // A stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("verdict dropped or changed under backpressure");

    // Input side never stalls unless a verdict is waiting
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("path input stalled with verdict slot free");

    // Padding bits of the verdict stay clear and the config channel stays ready
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'b0) && o_cfg_ready)
        else $error("verdict padding set or config channel blocked");

endmodule

bind path_glob_filter_match pgfm_checker u_pgfm_checker (.*);

`default_nettype wire

FILE: sim/path_glob_filter_match_tb.sv
`timescale 1ns / 1ps

// Testbench for the path glob filter.
// - The sender streams path bytes and closes each path with a tlast request.
// - A predictor inside the bench follows every accepted request and queues
//   the verdict that the block should give for that path.
// - A checker pops that queue on each verdict the block delivers.
// - Both sides idle at random. One phase holds off the receiver for a long
//   stretch so that verdicts pile up and the input side stalls.

module path_glob_filter_match_tb;
    import pgfm_pkg::*;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 10;
    localparam int          DRAIN_CYCLES = 8;       // idle time after the last verdict
    localparam int          HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          ITEMS_PER_CFG = 100;
    localparam int unsigned POS_SAT      = 17;

    typedef logic [7:0] path_t [$];

    // Shapes of one random path segment
    typedef enum int {
        SEG_FULL,     // the whole pattern
        SEG_PREFIX,   // the first bytes of the pattern
        SEG_HEAD,     // pattern, then filler
        SEG_TAIL,     // filler, then pattern
        SEG_SUFFIX,   // the last bytes of the pattern
        SEG_FILLER,   // bytes close to the pattern alphabet
        SEG_NOISE     // arbitrary bytes, sometimes a long run
    } seg_kind_e;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [7:0]           o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    path_glob_filter_match dut (.*);

    // Bench control
    bit          gaps_on = 1'b1;     // random idling on both sides
    bit          hold_go = 1'b0;     // toggle to start a receiver hold-off
    bit          hold_seen = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;

    logic expected_verdicts [$];

    // Predictor copy of the registers
    logic [MODE_W-1:0] cfg_mode = MODE_ROOT_EXACT;
    logic [LEN_W-1:0]  cfg_len = '0;
    logic [CFG_W-1:0]  cfg_lo = '0;
    logic [CFG_W-1:0]  cfg_hi = '0;

    // Predictor copy of the path state
    logic [7:0]  recent [PAT_BYTES];
    int unsigned path_pos;
    int unsigned comp_pos;
    bit          root_bad;
    bit          root_dir_ok;
    bit          comp_bad;
    bit          any_hit;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lengths above the pattern store act as a full pattern.
    function automatic int unsigned active_len();
        return (int'(cfg_len) > PAT_BYTES) ? PAT_BYTES : int'(cfg_len);
    endfunction

    function automatic logic [7:0] pat_at(int unsigned j);
        int unsigned k;
        k = j % PAT_BYTES;
        return (k < 8) ? cfg_lo[8*k +: 8] : cfg_hi[8*(k-8) +: 8];
    endfunction

    // True when the last n bytes seen spell the pattern, oldest byte first.
    function automatic bit tail_matches(int unsigned n);
        for (int unsigned j = 0; j < n; j++) begin
            if (recent[n - 1 - j] != pat_at(j)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_path();
        foreach (recent[k]) recent[k] = '0;
        path_pos    = 0;
        comp_pos    = 0;
        root_bad    = 1'b0;
        root_dir_ok = 1'b0;
        comp_bad    = 1'b0;
        any_hit     = 1'b0;
    endfunction

    function automatic void track_path_byte(logic [7:0] b);
        int unsigned n;
        n = active_len();
        // rooted compare against the start of the path
        if (path_pos < n && b != pat_at(path_pos)) root_bad = 1'b1;
        if (path_pos == n && b == SLASH) root_dir_ok = 1'b1;
        // pattern seen anywhere right before a slash
        if (b == SLASH && path_pos >= n && tail_matches(n)) any_hit = 1'b1;
        // last component: restart on every slash
        if (b == SLASH) begin
            comp_pos = 0;
            comp_bad = 1'b0;
        end else begin
            if (comp_pos < n && b != pat_at(comp_pos)) comp_bad = 1'b1;
            if (comp_pos < POS_SAT) comp_pos++;
        end
        if (path_pos < POS_SAT) path_pos++;
        for (int k = PAT_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
    endfunction

    // Verdict for the path so far; drops the path state afterward.
    function automatic logic finish_path();
        int unsigned n;
        logic        m;
        n = active_len();
        case (cfg_mode)
            MODE_ROOT_EXACT: m = !root_bad && path_pos == n;
            MODE_ROOT_DIR:   m = !root_bad && (path_pos == n || root_dir_ok);
            MODE_ANY_DIR:    m = any_hit || (path_pos >= n && tail_matches(n));
            MODE_LAST_EXACT: m = !comp_bad && comp_pos == n;
            MODE_LAST_START: m = !comp_bad && comp_pos >= n;
            MODE_LAST_END:   m = comp_pos >= n && tail_matches(n);
            default:         m = 1'b0;  // unused modes never match
        endcase
        clear_path();
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Drive tready: a requested hold-off first, then random idling.
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen  <= hold_go;
            stall_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (gaps_on) begin
            i_m_tready <= ($urandom_range(99) >= 20);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic void report_failure(string what, logic [7:0] exp_v, logic [7:0] act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("cycle %0d: %s: expected %h, got %h", cycle_count, what, exp_v, act_v);
    endfunction

    // Compare each delivered verdict with the oldest prediction.
    always @(posedge i_clk) begin
        logic exp_m;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_failure("verdict with none pending", 8'h00, o_m_tdata);
            end else begin
                exp_m = expected_verdicts.pop_front();
                if (o_m_tdata[0] !== exp_m)
                    report_failure("matched", {7'b0, exp_m}, o_m_tdata);
                if (o_m_tdata[7:1] !== 7'b0)
                    report_failure("tdata padding", {7'b0, exp_m}, o_m_tdata);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request; tvalid stays high after the handshake so that the
    // next request follows without a bubble.
    task automatic send_item(input logic [7:0] data, input logic last);
        while (gaps_on && $urandom_range(99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        if (last) expected_verdicts.push_back(finish_path());
        else      track_path_byte(data);
    endtask

    task automatic send_path(input path_t p);
        foreach (p[i]) send_item(p[i], 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);   // data byte ignored on the end request
    endtask

    // Drop tvalid and wait until every verdict is in and the pipe is empty.
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MATCH_MODE:   cfg_mode = data[MODE_W-1:0];
            REG_PATTERN_LEN:  cfg_len  = data[LEN_W-1:0];
            REG_PATTERN_LOW:  cfg_lo   = data;
            REG_PATTERN_HIGH: cfg_hi   = data;
            default: ;
        endcase
    endtask

    // Registers change only while the block is idle.
    task automatic set_config(input logic [MODE_W-1:0] mode_v, input logic [LEN_W-1:0] len_v,
                              input logic [CFG_W-1:0] lo_v, input logic [CFG_W-1:0] hi_v);
        quiesce();
        cfg_write(REG_MATCH_MODE, CFG_W'(mode_v));
        cfg_write(REG_PATTERN_LEN, CFG_W'(len_v));
        cfg_write(REG_PATTERN_LOW, lo_v);
        cfg_write(REG_PATTERN_HIGH, hi_v);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    // Small alphabet so that paths and patterns collide often.
    function automatic logic [7:0] filler_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 4) return pat_at($urandom_range(PAT_BYTES - 1));
        if (r < 6) return 8'h61;                // 'a'
        if (r < 7) return 8'h62;                // 'b'
        if (r < 8) return SLASH;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pattern_byte();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 8)  return 8'h61;
        if (r < 14) return 8'h62;
        if (r < 16) return 8'h63;
        if (r < 17) return SLASH;
        return 8'($urandom_range(255));
    endfunction

    // Build a path out of slash-separated segments shaped around the pattern.
    function automatic void make_path(output path_t p);
        int unsigned n;
        int unsigned segs;
        int unsigned cut;
        int unsigned extra;
        seg_kind_e   kind;
        n    = active_len();
        segs = $urandom_range(4);
        p    = {};
        if ($urandom_range(3) == 0) p.push_back(SLASH);
        for (int unsigned s = 0; s < segs; s++) begin
            if (s > 0) p.push_back(SLASH);
            kind  = seg_kind_e'($urandom_range(0, int'(SEG_NOISE)));
            cut   = $urandom_range(n);
            extra = $urandom_range(1, 3);
            case (kind)
                SEG_FULL: begin
                    for (int unsigned j = 0; j < n; j++) p.push_back(pat_at(j));
                end
                SEG_PREFIX: begin
                    for (int unsigned j = 0; j < cut; j++) p.push_back(pat_at(j));
                end
                SEG_HEAD: begin
                    for (int unsigned j = 0; j < n; j++) p.push_back(pat_at(j));
                    repeat (extra) p.push_back(filler_byte());
                end
                SEG_TAIL: begin
                    repeat (extra) p.push_back(filler_byte());
                    for (int unsigned j = 0; j < n; j++) p.push_back(pat_at(j));
                end
                SEG_SUFFIX: begin
                    for (int unsigned j = cut; j < n; j++) p.push_back(pat_at(j));
                end
                SEG_FILLER: begin
                    repeat ($urandom_range(5)) p.push_back(filler_byte());
                end
                default: begin
                    // occasionally run past the saturation point of the counters
                    if ($urandom_range(3) == 0) repeat ($urandom_range(18, 24))
                        p.push_back(8'($urandom_range(255)));
                    else repeat ($urandom_range(1, 4))
                        p.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        if ($urandom_range(4) == 0) p.push_back(SLASH);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: rooted exact with an empty pattern.
    task automatic test_reset_registers();
        path_t p;
        p = {};
        send_path(p);                      // empty path matches an empty pattern
        p = {8'h61};
        send_path(p);
    endtask

    // Every mode, the unused ones too, on the same pattern and path.
    task automatic test_each_mode();
        path_t p;
        for (int m = 0; m < 8; m++) begin
            set_config(MODE_W'(m), LEN_W'(2), 64'h0000_0000_0000_6261, 64'h0);  // "ab"
            p = {8'h61, 8'h62};
            send_path(p);
        end
    endtask

    // Empty pattern, over-long length, and the byte extremes.
    task automatic test_pattern_edges();
        path_t p;
        set_config(MODE_ANY_DIR, LEN_W'(0), 64'h0, 64'h0);
        p = {8'h71};
        send_path(p);
        set_config(MODE_ROOT_EXACT, LEN_W'(31), '1, '1);
        p = {8'hFF, 8'hFF};
        send_path(p);
        // zero is an ordinary byte, not a terminator
        set_config(MODE_ROOT_EXACT, LEN_W'(1), 64'h0, 64'h0);
        p = {8'h00};
        send_path(p);
    endtask

    // Change the pattern while a path is half done.
    task automatic test_config_mid_path();
        set_config(MODE_LAST_START, LEN_W'(2), 64'h0000_0000_0000_6261, 64'h0);
        send_item(8'h61, 1'b0);
        set_config(MODE_LAST_START, LEN_W'(2), 64'h0000_0000_0000_7861, 64'h0);  // "ax"
        send_item(8'h78, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Hold off the receiver while short paths keep coming, so the block
    // backs up and stalls its input.
    task automatic test_receiver_hold();
        path_t p;
        set_config(MODE_LAST_EXACT, LEN_W'(1), 64'h61, 64'h0);
        gaps_on = 1'b0;
        hold_go <= ~hold_go;
        repeat (60) begin
            p = {};
            repeat ($urandom_range(2)) p.push_back(filler_byte());
            send_path(p);
        end
        quiesce();
        gaps_on = 1'b1;
    endtask

    // Random configurations, each with a burst of random paths.
    task automatic test_random_paths();
        path_t             p;
        int unsigned       start;
        int unsigned       cfg_start;
        logic [MODE_W-1:0] mode_v;
        logic [LEN_W-1:0]  len_v;
        logic [CFG_W-1:0]  lo_v;
        logic [CFG_W-1:0]  hi_v;
        start = items_sent;
        for (int c = 0; items_sent - start < RANDOM_ITEMS; c++) begin
            mode_v = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(6, 7))
                                              : MODE_W'($urandom_range(5));
            len_v  = ($urandom_range(4) == 0) ? LEN_W'($urandom_range(7, 31))
                                              : LEN_W'($urandom_range(6));
            // force the extremes early on
            case (c)
                0: len_v = LEN_W'(0);
                1: len_v = LEN_W'(PAT_BYTES);
                2: len_v = LEN_W'(31);
                4: mode_v = 3'd7;
                default: ;
            endcase
            lo_v = {$urandom, $urandom};
            hi_v = {$urandom, $urandom};
            for (int j = 0; j < PAT_BYTES && j < int'(len_v); j++) begin
                if (j < 8) lo_v[8*j +: 8] = pattern_byte();
                else       hi_v[8*(j-8) +: 8] = pattern_byte();
            end
            set_config(mode_v, len_v, lo_v, hi_v);
            gaps_on   = (c != 3);          // one long stretch with no idling
            cfg_start = items_sent;
            while (items_sent - cfg_start < ITEMS_PER_CFG) begin
                make_path(p);
                send_path(p);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        clear_path();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_each_mode();
        test_pattern_edges();
        test_config_mid_path();
        test_receiver_hold();
        test_random_paths();

        quiesce();
        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
